// ----- design/vmu_pkg.sv -----
// vmu_pkg: shared types, operation codes and helper functions for the vector math unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps

package vmu_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    FN_LEN   = 3'd0,
    FN_NORM  = 3'd1,
    FN_INV   = 3'd2,
    FN_CROSS = 3'd3,
    FN_ADD   = 3'd4,
    FN_MUL   = 3'd5,
    FN_ROT   = 3'd6,
    FN_EQ    = 3'd7
  } func_t;

  // square root pipeline: two radicand bits per stage over a 64-bit sum
  localparam int SQRT_LAT = 32;

  // one item as it moves down the main pipeline
  typedef struct packed {
    func_t           func;
    word_t [2:0]     a;
    word_t [2:0]     r;
    logic  [31:0]    len;
    logic            keep;
    logic            eq;
  } item_t;

  // per-stage operation codes seen by the lanes
  typedef struct packed {
    func_t f0;
    func_t f1;
    func_t f2;
    func_t f3;
  } lane_ctl_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t res;
    if (v > 64'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [31:0] abs32(input word_t v);
    logic [31:0] res;
    res = v[31] ? (32'd0 - v) : v;
    return res;
  endfunction

endpackage

// ----- design/vmu_sqrt.sv -----
// vmu_sqrt: pipelined integer square root, one result bit per stage
// depends on vmu_pkg (SQRT_LAT)
`timescale 1ns / 1ps

module vmu_sqrt import vmu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [34:0] rem_r  [SQRT_LAT];
  logic [31:0] root_r [SQRT_LAT];
  logic [63:0] n_r    [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] n_in;
    logic [34:0] rem_s;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
    end

    assign rem_s = {rem_in[32:0], n_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= {n_in[61:0], 2'b00};
        if (rem_s >= trial) begin
          rem_r[k]  <= rem_s - trial;
          root_r[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_s;
          root_r[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

// ----- design/vmu_div.sv -----
// vmu_div: pipelined restoring divider for normalize, (num << FRAC_BITS) / den
// depends on vmu_pkg; needs num <= den so the quotient fits FRAC_BITS+1 bits
`timescale 1ns / 1ps

module vmu_div import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output logic [FRAC_BITS:0]   quo
);

  localparam int QW = FRAC_BITS + 1;

  logic [31:0]   rem_r [QW];
  logic [31:0]   den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [31:0]   rem_in;
    logic [31:0]   den_in;
    logic [QW-1:0] q_in;
    logic          nb;
    logic [32:0]   rem_s;

    if (j == 0) begin : g_first
      // upper dividend bits are below den, so start from them directly
      assign rem_in = {1'b0, num[31:1]};
      assign den_in = den;
      assign q_in   = '0;
      assign nb     = num[0];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign nb     = 1'b0;
    end

    assign rem_s = {rem_in, nb};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_in;
        if (rem_s >= {1'b0, den_in}) begin
          rem_r[j] <= 32'(rem_s - {1'b0, den_in});
          q_r[j]   <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem_r[j] <= rem_s[31:0];
          q_r[j]   <= {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ----- design/vmu_quat.sv -----
// vmu_quat: rotation matrix from a quaternion, two register stages
// depends on vmu_pkg (word_t, sat32)
`timescale 1ns / 1ps

module vmu_quat import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  word_t             qx,
  input  word_t             qy,
  input  word_t             qz,
  input  word_t             qw,
  output word_t [2:0][2:0]  m_r
);

  logic signed [63:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [63:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= $signed(qx) * $signed(qx);
      yy_r <= $signed(qy) * $signed(qy);
      zz_r <= $signed(qz) * $signed(qz);
      ww_r <= $signed(qw) * $signed(qw);
      xy_r <= $signed(qx) * $signed(qy);
      xz_r <= $signed(qx) * $signed(qz);
      yz_r <= $signed(qy) * $signed(qz);
      wx_r <= $signed(qw) * $signed(qx);
      wy_r <= $signed(qw) * $signed(qy);
      wz_r <= $signed(qw) * $signed(qz);
    end
  end

  // round each product down to the fixed-point grid
  assign xx = xx_r >>> FRAC_BITS;
  assign yy = yy_r >>> FRAC_BITS;
  assign zz = zz_r >>> FRAC_BITS;
  assign ww = ww_r >>> FRAC_BITS;
  assign xy = xy_r >>> FRAC_BITS;
  assign xz = xz_r >>> FRAC_BITS;
  assign yz = yz_r >>> FRAC_BITS;
  assign wx = wx_r >>> FRAC_BITS;
  assign wy = wy_r >>> FRAC_BITS;
  assign wz = wz_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0][0] <= sat32(ww + xx - yy - zz);
      m_r[0][1] <= sat32(2 * xy - 2 * wz);
      m_r[0][2] <= sat32(2 * wy + 2 * xz);
      m_r[1][0] <= sat32(2 * xy + 2 * wz);
      m_r[1][1] <= sat32(ww - xx + yy - zz);
      m_r[1][2] <= sat32(2 * yz - 2 * wx);
      m_r[2][0] <= sat32(2 * xz - 2 * wy);
      m_r[2][1] <= sat32(2 * yz + 2 * wx);
      m_r[2][2] <= sat32(ww - xx - yy + zz);
    end
  end

endmodule

// ----- design/vmu_lane.sv -----
// vmu_lane: one vector component lane, four register stages
// depends on vmu_pkg (word_t, func_t, lane_ctl_t, sat32, abs32)
`timescale 1ns / 1ps

module vmu_lane import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         en,
  input  lane_ctl_t    ctl,
  input  word_t        a_self,
  input  word_t        a_n1,
  input  word_t        a_n2,
  input  word_t        b_self,
  input  word_t        b_n1,
  input  word_t        b_n2,
  input  word_t [2:0]  m_row,
  input  word_t [2:0]  a_rot,
  output logic  [63:0] sq_r,
  output word_t        res_r
);

  logic signed [63:0] pa_r, pb_r, pm_r;
  logic signed [63:0] rp_r [3];
  word_t              simple_r, r2_r, r3_r;
  logic signed [63:0] ae, be, rot_sum;
  logic [31:0]        amag;

  assign ae   = 64'($signed(a_self));
  assign be   = 64'($signed(b_self));
  assign amag = abs32(a_self);

  // stage 1: products and the single-step operations
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= amag * amag;
      pa_r <= $signed(a_n1) * $signed(b_n2);
      pb_r <= $signed(b_n1) * $signed(a_n2);
      pm_r <= $signed(a_self) * $signed(b_self);
      if (ctl.f0 == FN_INV) begin
        simple_r <= sat32(-ae);
      end else begin
        simple_r <= sat32(ae + be);
      end
    end
  end

  // stage 2: rescale and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      case (ctl.f1)
        FN_CROSS:       r2_r <= sat32((pa_r >>> FRAC_BITS) - (pb_r >>> FRAC_BITS));
        FN_MUL:         r2_r <= sat32(pm_r >>> FRAC_BITS);
        FN_ADD, FN_INV: r2_r <= simple_r;
        default:        r2_r <= '0;
      endcase
    end
  end

  // stage 3: matrix row times vector a
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rp_r[j] <= $signed(m_row[j]) * $signed(a_rot[j]);
      end
      r3_r <= r2_r;
    end
  end

  assign rot_sum = (rp_r[0] >>> FRAC_BITS) + (rp_r[1] >>> FRAC_BITS)
                 + (rp_r[2] >>> FRAC_BITS);

  // stage 4: lane result
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= (ctl.f3 == FN_ROT) ? sat32(rot_sum) : r3_r;
    end
  end

endmodule

// ----- design/vector3_math_unit.sv -----
// vector3_math_unit: top level of the fixed-point 3D vector unit
// depends on vmu_pkg, vmu_lane, vmu_quat, vmu_sqrt, vmu_div
`timescale 1ns / 1ps

// A fully pipelined 3D vector unit in signed fixed point (FRAC_BITS fraction
// bits, Q16.16 at the default). It takes one input beat per clock while
// in_stall is low and returns one result beat per input beat, in order. Every
// operation passes through the same stages; the depth is set by the 32-stage
// square root followed by the FRAC_BITS+1 stage normalize divider. The whole
// pipeline advances together: it freezes only while a result sits in the
// output register and out_stall is high, so in_stall follows that condition.
// The normalize threshold is written through the cfg port (always ready) and
// must only change while the pipeline is empty.
module vector3_math_unit import vmu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by,
  input  logic signed [31:0] in_bz,
  input  logic signed [31:0] in_bw,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic signed [31:0] out_rz,
  output logic [30:0]        out_magnitude,
  output logic               out_is_equal,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int QW      = FRAC_BITS + 1;
  localparam int SUM_STG = 2;                       // sum of squares register
  localparam int VEC_STG = 5;                       // lane results join the item
  localparam int LEN_STG = SUM_STG + SQRT_LAT + 1;  // root joins the item
  localparam int LAT     = LEN_STG + QW + 1;        // output register

  // pipeline state
  logic [LAT:0] v_r;
  item_t        pipe_r   [LAT+1];
  item_t        pipe_nxt [LAT+1];
  word_t        bx_r, by_r, bz_r, bw_r;
  logic [15:0]  thr_r;
  logic         en;

  // datapath links
  word_t [2:0][2:0]  m_r;
  logic  [63:0]      sq   [3];
  word_t             lane_res [3];
  logic  [63:0]      sum_r;
  logic  [31:0]      root;
  logic  [FRAC_BITS:0] quo [3];
  lane_ctl_t         ctl;
  word_t [2:0]       b0;
  logic              eq_s;
  logic              keep_s;

  // whole pipe moves unless the output beat is held
  assign en        = !(v_r[LAT] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-1:0], in_valid};
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0].func <= func_t'(in_func);
      pipe_r[0].a    <= {in_az, in_ay, in_ax};
      pipe_r[0].r    <= '0;
      pipe_r[0].len  <= '0;
      pipe_r[0].keep <= 1'b0;
      pipe_r[0].eq   <= 1'b0;
      bx_r <= in_bx;
      by_r <= in_by;
      bz_r <= in_bz;
      bw_r <= in_bw;
    end
  end

  assign pipe_nxt[0] = pipe_r[0];
  assign b0 = {bz_r, by_r, bx_r};

  assign eq_s = (pipe_r[0].func == FN_EQ) && (pipe_r[0].a == b0);

  assign ctl.f0 = pipe_r[0].func;
  assign ctl.f1 = pipe_r[1].func;
  assign ctl.f2 = pipe_r[2].func;
  assign ctl.f3 = pipe_r[3].func;

  // quaternion to rotation matrix, valid alongside stage 2
  vmu_quat #(.FRAC_BITS(FRAC_BITS)) u_quat (
    .clk (clk),
    .en  (en),
    .qx  (bx_r),
    .qy  (by_r),
    .qz  (bz_r),
    .qw  (bw_r),
    .m_r (m_r)
  );

  // one lane per component; cross product pulls the two other components
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vmu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .ctl    (ctl),
      .a_self (pipe_r[0].a[i]),
      .a_n1   (pipe_r[0].a[(i+1)%3]),
      .a_n2   (pipe_r[0].a[(i+2)%3]),
      .b_self (b0[i]),
      .b_n1   (b0[(i+1)%3]),
      .b_n2   (b0[(i+2)%3]),
      .m_row  (m_r[i]),
      .a_rot  (pipe_r[2].a),
      .sq_r   (sq[i]),
      .res_r  (lane_res[i])
    );
  end

  // sum of squares cannot overflow 64 bits (at most 3 * 2^62)
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sq[0] + sq[1] + sq[2];
    end
  end

  vmu_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum_r),
    .root     (root)
  );

  assign keep_s = (pipe_r[LEN_STG-1].func == FN_NORM) && (root > {16'd0, thr_r});

  // normalize dividers, one per component; zero-length inputs are masked by keep
  for (genvar i = 0; i < 3; i++) begin : g_div
    vmu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (abs32(pipe_r[LEN_STG].a[i])),
      .den (pipe_r[LEN_STG].len),
      .quo (quo[i])
    );
  end

  // main item pipeline: fields are filled in at the stage where they appear
  for (genvar k = 1; k <= LAT; k++) begin : g_pipe
    always_comb begin
      pipe_nxt[k] = pipe_r[k-1];
      if (k == 1) begin
        pipe_nxt[k].eq = eq_s;
      end
      if (k == VEC_STG) begin
        for (int i = 0; i < 3; i++) begin
          pipe_nxt[k].r[i] = lane_res[i];
        end
      end
      if (k == LEN_STG) begin
        pipe_nxt[k].len  = root;
        pipe_nxt[k].keep = keep_s;
      end
      if (k == LAT) begin
        if (pipe_r[k-1].func == FN_NORM) begin
          for (int i = 0; i < 3; i++) begin
            if (!pipe_r[k-1].keep) begin
              pipe_nxt[k].r[i] = '0;
            end else if (pipe_r[k-1].a[i][31]) begin
              pipe_nxt[k].r[i] = 32'd0 - {{(32-QW){1'b0}}, quo[i]};
            end else begin
              pipe_nxt[k].r[i] = {{(32-QW){1'b0}}, quo[i]};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // merge: output register is the last pipeline stage
  assign out_valid    = v_r[LAT];
  assign out_rx       = pipe_r[LAT].r[0];
  assign out_ry       = pipe_r[LAT].r[1];
  assign out_rz       = pipe_r[LAT].r[2];
  assign out_is_equal = pipe_r[LAT].eq;

  always_comb begin
    if (pipe_r[LAT].func == FN_LEN || pipe_r[LAT].func == FN_NORM) begin
      out_magnitude = pipe_r[LAT].len[31] ? 31'h7fff_ffff : pipe_r[LAT].len[30:0];
    end else begin
      out_magnitude = '0;
    end
  end

  // an accepted beat always enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted beat lost at pipeline entry");

  // equality result never carries a vector
  a_eq_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_equal) |-> (out_rx == 0 && out_ry == 0 && out_rz == 0))
    else $error("equal result with nonzero vector");

  // magnitude only for length and normalize
  a_mag_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(pipe_r[LAT].func == FN_LEN || pipe_r[LAT].func == FN_NORM))
      |-> (out_magnitude == 0))
    else $error("magnitude set for an operation without length");

  // a held output beat keeps the pipe frozen
  a_hold_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(v_r))
    else $error("pipeline advanced under output stall");

endmodule

// ----- bench/tb_vector3_math_unit.sv -----
// tb_vector3_math_unit: self-checking bench for the fixed-point 3D vector unit
// depends on vmu_pkg and vector3_math_unit; predicts every result beat in order
`timescale 1ns / 1ps

module tb_vector3_math_unit;
  import vmu_pkg::*;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [30:0] mag;
    logic        eq;
  } vec_res_t;

  // expected result beats, oldest first; mismatches are counted, the run goes on
  class vec_result_board;
    vec_res_t pending[$];
    int errors;
    int checked;

    function void note_item(vec_res_t r);
      pending.push_back(r);
    endfunction

    function void check_beat(vec_res_t got);
      vec_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat rx=%h", $time, got.rx);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.rx !== want.rx) begin
        $display("%0t: rx expected %h actual %h", $time, want.rx, got.rx);
        errors++;
      end
      if (got.ry !== want.ry) begin
        $display("%0t: ry expected %h actual %h", $time, want.ry, got.ry);
        errors++;
      end
      if (got.rz !== want.rz) begin
        $display("%0t: rz expected %h actual %h", $time, want.rz, got.rz);
        errors++;
      end
      if (got.mag !== want.mag) begin
        $display("%0t: magnitude expected %h actual %h", $time, want.mag, got.mag);
        errors++;
      end
      if (got.eq !== want.eq) begin
        $display("%0t: is_equal expected %b actual %b", $time, want.eq, got.eq);
        errors++;
      end
    endfunction
  endclass

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 37;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1630;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic signed [31:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [31:0] in_bx = '0, in_by = '0, in_bz = '0, in_bw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_rx, out_ry, out_rz;
  logic [30:0] out_magnitude;
  logic out_is_equal;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  vec_result_board board = new();
  logic [15:0] threshold = '0;   // predictor copy of the normalize threshold
  longint cycles = 0;
  int stall_mode = 0;
  int sent = 0;

  always #1 clk = ~clk;

  vector3_math_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz), .in_bw(in_bw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_magnitude(out_magnitude), .out_is_equal(out_is_equal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------- predictor ----------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // fixed-point product, floor toward minus infinity via arithmetic shift
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec_res_t predict_vector(
      func_t fn, longint a[3], longint b[3], longint w);
    vec_res_t res;
    longint r[3], m[3][3], acc;
    longint xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
    logic [63:0] sum, len, mg, q;
    r = '{0, 0, 0};
    res = '0;
    case (fn)
      FN_LEN, FN_NORM: begin
        sum = 0;
        for (int i = 0; i < 3; i++) sum += (a[i] < 0 ? -a[i] : a[i]) ** 2;
        len = root64(sum);
        mg = len > 64'd2147483647 ? 64'd2147483647 : len;
        res.mag = mg[30:0];
        if (fn == FN_NORM && len > threshold)
          for (int i = 0; i < 3; i++) begin
            q = ((a[i] < 0 ? -a[i] : a[i]) << FRAC) / len;
            r[i] = a[i] < 0 ? -longint'(q) : longint'(q);
          end
      end
      FN_INV: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i]);
      FN_CROSS: begin
        r[0] = clamp32(qmul(a[1], b[2]) - qmul(b[1], a[2]));
        r[1] = clamp32(qmul(a[2], b[0]) - qmul(b[2], a[0]));
        r[2] = clamp32(qmul(a[0], b[1]) - qmul(b[0], a[1]));
      end
      FN_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i]);
      FN_MUL: for (int i = 0; i < 3; i++) r[i] = clamp32(qmul(a[i], b[i]));
      FN_ROT: begin
        xx = qmul(b[0], b[0]); yy = qmul(b[1], b[1]);
        zz = qmul(b[2], b[2]); ww = qmul(w, w);
        xy = qmul(b[0], b[1]); xz = qmul(b[0], b[2]); yz = qmul(b[1], b[2]);
        wx = qmul(w, b[0]); wy = qmul(w, b[1]); wz = qmul(w, b[2]);
        m[0][0] = ww + xx - yy - zz;
        m[0][1] = 2 * xy - 2 * wz;
        m[0][2] = 2 * wy + 2 * xz;
        m[1][0] = 2 * xy + 2 * wz;
        m[1][1] = ww - xx + yy - zz;
        m[1][2] = 2 * yz - 2 * wx;
        m[2][0] = 2 * xz - 2 * wy;
        m[2][1] = 2 * yz + 2 * wx;
        m[2][2] = ww - xx - yy + zz;
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += qmul(clamp32(m[i][j]), a[j]);
          r[i] = clamp32(acc);
        end
      end
      default: res.eq = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
    endcase
    res.rx = r[0][31:0];
    res.ry = r[1][31:0];
    res.rz = r[2][31:0];
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(func_t fn, logic [31:0] v[7]);
    in_valid <= 1'b1;
    in_func <= fn;
    in_ax <= v[0]; in_ay <= v[1]; in_az <= v[2];
    in_bx <= v[3]; in_by <= v[4]; in_bz <= v[5]; in_bw <= v[6];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(predict_vector(fn,
      '{longint'($signed(v[0])), longint'($signed(v[1])), longint'($signed(v[2]))},
      '{longint'($signed(v[3])), longint'($signed(v[4])), longint'($signed(v[5]))},
      longint'($signed(v[6]))));
    sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pipeline drains, then the threshold may change
  task automatic write_threshold(logic [15:0] val);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold = val;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3);
      3: return 32'd0 - $urandom_range(0, 3);
      4, 5: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
      6: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // ---------------- result monitor ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      board.check_beat({out_rx, out_ry, out_rz, out_magnitude, out_is_equal});
    // receiver pattern: no stalls, sparse, heavy, or periodic
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 7) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycles % 7) < 3;
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  logic [31:0] v[7];
  logic [31:0] big;
  func_t fn;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation on extremes, special cases at threshold zero
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    for (int f = 0; f < 8; f++) send_item(func_t'(f), v);
    v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    for (int f = 0; f < 8; f++) send_item(func_t'(f), v);
    v = '{0, 0, 0, 0, 0, 0, 0};
    send_item(FN_NORM, v);             // zero-length vector normalizes to zero
    send_item(FN_EQ, v);
    v = '{32'h0001_0000, 0, 0, 0, 0, 32'h0000_b505, 32'h0000_b505};
    send_item(FN_ROT, v);              // quarter turn about z
    send_item(FN_NORM, v);
    v = '{1, 0, 0, 1, 0, 0, 0};
    send_item(FN_NORM, v);             // length one, just above threshold zero
    v = '{32'hffff_ffff, 2, 3, 32'hffff_ffff, 2, 4, 5};
    send_item(FN_EQ, v);               // differs only in z

    // threshold sweep: extremes plus random, random beats in between
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_threshold(16'hffff);
        1: write_threshold(16'd0);
        2: write_threshold(16'd1);
        default: write_threshold(16'($urandom));
      endcase
      // lengths near the threshold so both sides of the compare are hit
      for (int k = 0; k < 6; k++) begin
        big = threshold + $urandom_range(0, 2) - 1;
        v = '{big, 0, 0, 0, 0, 0, 0};
        send_item(FN_NORM, v);
      end
      while (sent < (phase + 1) * (RANDOM_ITEMS / 6) + 22) begin
        for (int b = $urandom_range(1, 40); b > 0; b--) begin
          fn = func_t'($urandom_range(0, 7));
          for (int i = 0; i < 7; i++) v[i] = rand_word();
          if (fn == FN_EQ && $urandom_range(0, 1)) begin
            v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
            if ($urandom_range(0, 2) == 0) v[3 + $urandom_range(0, 2)] ^= 1 << $urandom_range(0, 31);
          end
          send_item(fn, v);
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      end
    end

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d input beats over 6 threshold settings, %0d results checked",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
